[design/fhc_pkg.sv]
package fhc_pkg;

  localparam int unsigned HeaderBytes = 17;
  localparam int unsigned CrcSpan     = 16;
  localparam int unsigned CountW      = 17;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [7:0] CrcPoly = 8'h07;

  localparam logic [CfgIndexW-1:0] CFG_EXPECTED_MAGIC   = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_EXPECTED_VERSION = 2'd1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_PROTOCOL  = 2'd2;
  localparam logic [1:0] STATUS_CRC_ERROR = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  frame_flags;
    logic [7:0]  stream_id;
    logic [15:0] body_len;
    logic [31:0] seq_number;
    logic [31:0] timestamp_us;
  } out_t;

  typedef struct packed {
    logic [15:0] magic;
    logic [7:0]  version;
  } cfg_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

[design/fhc_parser.sv]
module fhc_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  fhc_pkg::in_t  in_data,
  input  fhc_pkg::cfg_t cfg,
  output logic          res_valid,
  output fhc_pkg::out_t res_data
);
  import fhc_pkg::*;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CountW-1:0] HdrCount = CountW'(HeaderBytes);
  localparam logic [CountW-1:0] CrcCount = CountW'(CrcSpan);

  logic [CountW-1:0] byte_count, byte_count_next;
  logic [7:0]        crc_acc, crc_acc_next;
  logic [15:0]       hdr_magic, hdr_magic_next;
  logic [7:0]        hdr_version, hdr_version_next;
  logic [7:0]        hdr_flags, hdr_flags_next;
  logic [7:0]        hdr_stream, hdr_stream_next;
  logic [7:0]        hdr_reserved, hdr_reserved_next;
  logic [15:0]       hdr_length, hdr_length_next;
  logic [31:0]       hdr_seq, hdr_seq_next;
  logic [31:0]       hdr_time, hdr_time_next;
  logic [7:0]        hdr_crc, hdr_crc_next;

  logic [CountW-1:0] payload_pos;
  logic [CountW:0]   need_count;
  logic              crc_en;
  logic [1:0]        status;
  logic [7:0]        b;

  assign b = in_data.data_byte;

  always_comb begin
    hdr_magic_next    = hdr_magic;
    hdr_version_next  = hdr_version;
    hdr_flags_next    = hdr_flags;
    hdr_stream_next   = hdr_stream;
    hdr_reserved_next = hdr_reserved;
    hdr_length_next   = hdr_length;
    hdr_seq_next      = hdr_seq;
    hdr_time_next     = hdr_time;
    hdr_crc_next      = hdr_crc;
    if (byte_count < HdrCount) begin
      case (byte_count[4:0])
        5'd0:    hdr_magic_next[7:0]   = b;
        5'd1:    hdr_magic_next[15:8]  = b;
        5'd2:    hdr_version_next      = b;
        5'd3:    hdr_flags_next        = b;
        5'd4:    hdr_stream_next       = b;
        5'd5:    hdr_reserved_next     = b;
        5'd6:    hdr_length_next[7:0]  = b;
        5'd7:    hdr_length_next[15:8] = b;
        5'd8:    hdr_seq_next[7:0]     = b;
        5'd9:    hdr_seq_next[15:8]    = b;
        5'd10:   hdr_seq_next[23:16]   = b;
        5'd11:   hdr_seq_next[31:24]   = b;
        5'd12:   hdr_time_next[7:0]    = b;
        5'd13:   hdr_time_next[15:8]   = b;
        5'd14:   hdr_time_next[23:16]  = b;
        5'd15:   hdr_time_next[31:24]  = b;
        5'd16:   hdr_crc_next          = b;
        default: ;
      endcase
    end

    payload_pos = byte_count - HdrCount;
    crc_en = (byte_count < CrcCount) ||
             ((byte_count >= HdrCount) && (payload_pos < {1'b0, hdr_length}));
    crc_acc_next = crc_en ? crc8_byte(crc_acc, b) : crc_acc;
    byte_count_next = (byte_count == CountMax) ? byte_count : byte_count + 1'b1;

    need_count = {1'b0, HdrCount} + {2'b00, hdr_length_next};
    if (byte_count_next < HdrCount) begin
      status = STATUS_SHORT;
    end else if (hdr_magic_next != cfg.magic || hdr_version_next != cfg.version ||
                 hdr_reserved_next != 8'd0) begin
      status = STATUS_PROTOCOL;
    end else if ({1'b0, byte_count_next} < need_count) begin
      status = STATUS_PROTOCOL;
    end else if (hdr_crc_next != crc_acc_next) begin
      status = STATUS_CRC_ERROR;
    end else begin
      status = STATUS_OK;
    end

    res_valid = accept && in_data.last_byte;
    res_data  = '0;
    res_data.status = status;
    if (status == STATUS_OK) begin
      res_data.frame_flags  = hdr_flags_next;
      res_data.stream_id    = hdr_stream_next;
      res_data.body_len     = hdr_length_next;
      res_data.seq_number   = hdr_seq_next;
      res_data.timestamp_us = hdr_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.last_byte)) begin
      byte_count   <= '0;
      crc_acc      <= '0;
      hdr_magic    <= '0;
      hdr_version  <= '0;
      hdr_flags    <= '0;
      hdr_stream   <= '0;
      hdr_reserved <= '0;
      hdr_length   <= '0;
      hdr_seq      <= '0;
      hdr_time     <= '0;
      hdr_crc      <= '0;
    end else if (accept) begin
      byte_count   <= byte_count_next;
      crc_acc      <= crc_acc_next;
      hdr_magic    <= hdr_magic_next;
      hdr_version  <= hdr_version_next;
      hdr_flags    <= hdr_flags_next;
      hdr_stream   <= hdr_stream_next;
      hdr_reserved <= hdr_reserved_next;
      hdr_length   <= hdr_length_next;
      hdr_seq      <= hdr_seq_next;
      hdr_time     <= hdr_time_next;
      hdr_crc      <= hdr_crc_next;
    end
  end

endmodule

[design/fhc_skid.sv]
module fhc_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fhc_pkg::out_t push_data,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output fhc_pkg::out_t out_data
);
  import fhc_pkg::*;

  logic skid_valid;
  out_t skid_data;

  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

[design/frame_header_check_crc8.sv]
// channel | direction | handshake             | payload
// input   | in        | in_valid / in_ready   | in_data  (data_byte, last_byte)
// output  | out       | out_valid / out_ready | out_data (status and header fields)
// config  | in        | cfg_we                | cfg_index, cfg_data
// One byte is taken per cycle while in_ready is high; header capture and the CRC-8
// update finish in that cycle. A result is registered in out_data, or skid_data if stalled.
// A two-entry output buffer holds results; in_ready drops only while both entries are full.
// Synchronous reset clears frame state, buffer valid flags and configuration to zero.
module frame_header_check_crc8 (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fhc_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fhc_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [fhc_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [fhc_pkg::CfgDataW-1:0]     cfg_data
);
  import fhc_pkg::*;

  cfg_t cfg;
  logic accept;
  logic res_valid;
  out_t res_data;
  logic space;

  assign in_ready = space;
  assign accept   = in_valid && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_MAGIC:   cfg.magic   <= cfg_data;
        CFG_EXPECTED_VERSION: cfg.version <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  fhc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_data   (in_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  fhc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
